[rtl/core/jkvl_pkg.sv]
`default_nettype none

package jkvl_pkg;

    // Default sizing
    localparam int MAX_KEY_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF   = 16;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int KEY_LEN_W  = 5;
    localparam int KEY_WORD_W = 64;
    localparam int REPORT_W   = 16;
    localparam int DEPTH_W    = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd2;

    // Document characters
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // One search result
    typedef struct packed {
        logic                found;
        logic [REPORT_W-1:0] value_offset;
        logic [REPORT_W-1:0] value_length;
    } result_t;

    // Space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    // Fold upper-case ASCII letters to lower case
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/jkvl_scan.sv]
`default_nettype none

module jkvl_scan #(
    parameter int MAX_KEY_BYTES = jkvl_pkg::MAX_KEY_BYTES_DEF,
    parameter int OFFSET_BITS   = jkvl_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic [jkvl_pkg::KEY_LEN_W-1:0]          key_length,
    input  wire logic [2*jkvl_pkg::KEY_WORD_W-1:0]       key_bytes,
    input  wire logic                                    byte_en,
    input  wire logic [jkvl_pkg::BYTE_W-1:0]             doc_byte,
    input  wire logic                                    last_byte,
    output logic                                         res_valid,
    output jkvl_pkg::result_t                            res
);

    localparam int KIDX_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int KSEL_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    typedef enum logic [3:0] {
        PH_START,
        PH_SCAN,
        PH_NAME,
        PH_SKIPSTR,
        PH_NESTED,
        PH_END,
        PH_PRECOLON,
        PH_POSTCOLON,
        PH_VALUE,
        PH_VDONE
    } phase_t;

    phase_t                          phase_reg,  phase_next;
    logic [OFFSET_BITS-1:0]          pos_reg;
    logic [jkvl_pkg::DEPTH_W-1:0]    depth_reg,  depth_next;
    logic                            quote_reg,  quote_next;
    logic [KIDX_W-1:0]               kidx_reg,   kidx_next;
    logic [OFFSET_BITS-1:0]          vstart_reg, vstart_next;
    logic [OFFSET_BITS-1:0]          vend_reg,   vend_next;

    logic [OFFSET_BITS-1:0]          pos_inc;
    logic [KIDX_W-1:0]               eff_len;
    logic [KSEL_W-1:0]               key_sel;
    logic [jkvl_pkg::BYTE_W-1:0]     key_byte;
    logic                            name_hit;
    logic                            b_ws, b_quote, b_lbrace, b_rbrace, b_comma, b_colon;
    logic                            run_value;
    logic                            found_next;
    logic [OFFSET_BITS-1:0]          vlen_next;
    logic [OFFSET_BITS+jkvl_pkg::REPORT_W-1:0] start_ext, len_ext;

    assign pos_inc  = pos_reg + 1'b1;
    assign eff_len  = (key_length > jkvl_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) ?
                      KIDX_W'(MAX_KEY_BYTES) : KIDX_W'(key_length);
    assign key_sel  = kidx_reg[KSEL_W-1:0];
    assign key_byte = key_bytes[8*key_sel +: 8];
    assign name_hit = (jkvl_pkg::fold_case(doc_byte) == jkvl_pkg::fold_case(key_byte));

    assign b_ws     = jkvl_pkg::is_ws(doc_byte);
    assign b_quote  = (doc_byte == jkvl_pkg::CH_QUOTE);
    assign b_lbrace = (doc_byte == jkvl_pkg::CH_LBRACE);
    assign b_rbrace = (doc_byte == jkvl_pkg::CH_RBRACE);
    assign b_comma  = (doc_byte == jkvl_pkg::CH_COMMA);
    assign b_colon  = (doc_byte == jkvl_pkg::CH_COLON);

    always_comb begin
        phase_next  = phase_reg;
        depth_next  = depth_reg;
        quote_next  = quote_reg;
        kidx_next   = kidx_reg;
        vstart_next = vstart_reg;
        vend_next   = vend_reg;
        run_value   = 1'b0;

        case (phase_reg)
            PH_START, PH_SCAN: begin
                if (b_quote) begin
                    phase_next = PH_NAME;
                    kidx_next  = '0;
                end else if (b_lbrace) begin
                    if (phase_reg == PH_START) begin
                        phase_next = PH_SCAN;
                    end else begin
                        depth_next = jkvl_pkg::DEPTH_W'(1);
                        quote_next = 1'b0;
                        phase_next = PH_NESTED;
                    end
                end else if (b_rbrace) begin
                    phase_next = PH_END;
                end
            end
            PH_NAME: begin
                if ((kidx_reg < eff_len) && name_hit) begin
                    kidx_next = kidx_reg + 1'b1;
                end else if ((kidx_reg >= eff_len) && b_quote) begin
                    vstart_next = pos_inc;
                    vend_next   = pos_inc;
                    depth_next  = '0;
                    quote_next  = 1'b0;
                    phase_next  = PH_PRECOLON;
                end else begin
                    phase_next = b_quote ? PH_SCAN : PH_SKIPSTR;
                end
            end
            PH_SKIPSTR: begin
                if (b_quote) begin
                    phase_next = PH_SCAN;
                end
            end
            PH_NESTED: begin
                if (quote_reg) begin
                    if (b_quote) begin
                        quote_next = 1'b0;
                    end
                end else if (b_quote) begin
                    quote_next = 1'b1;
                end else if (b_lbrace) begin
                    if (depth_reg != jkvl_pkg::DEPTH_MAX) begin
                        depth_next = depth_reg + 1'b1;
                    end
                end else if (b_rbrace) begin
                    if (depth_reg <= jkvl_pkg::DEPTH_W'(1)) begin
                        depth_next = '0;
                        phase_next = PH_SCAN;
                    end else begin
                        depth_next = depth_reg - 1'b1;
                    end
                end
            end
            PH_PRECOLON, PH_POSTCOLON: begin
                if (b_ws || ((phase_reg == PH_PRECOLON) && b_colon)) begin
                    if (b_colon) begin
                        phase_next = PH_POSTCOLON;
                    end
                    vstart_next = pos_inc;
                    vend_next   = pos_inc;
                end else begin
                    phase_next = PH_VALUE;
                    run_value  = 1'b1;
                end
            end
            PH_VALUE: begin
                run_value = 1'b1;
            end
            default: begin
            end
        endcase

        // Value body: count braces, stop on a top-level comma or closing brace
        if (run_value) begin
            if (quote_reg) begin
                if (b_quote) begin
                    quote_next = 1'b0;
                end
            end else if (depth_reg != '0) begin
                if (b_lbrace) begin
                    if (depth_reg != jkvl_pkg::DEPTH_MAX) begin
                        depth_next = depth_reg + 1'b1;
                    end
                end else if (b_rbrace) begin
                    depth_next = depth_reg - 1'b1;
                end
            end else if (b_quote) begin
                quote_next = 1'b1;
            end else if (b_lbrace) begin
                depth_next = jkvl_pkg::DEPTH_W'(1);
            end else if (b_rbrace || b_comma) begin
                phase_next = PH_VDONE;
            end
            if (!b_ws && !(!quote_reg && (depth_reg == '0) && (b_rbrace || b_comma))) begin
                vend_next = pos_inc;
            end
        end
    end

    assign found_next = (phase_next == PH_PRECOLON) || (phase_next == PH_POSTCOLON) ||
                        (phase_next == PH_VALUE)    || (phase_next == PH_VDONE);
    assign vlen_next  = vend_next - vstart_next;
    assign start_ext  = {{jkvl_pkg::REPORT_W{1'b0}}, vstart_next};
    assign len_ext    = {{jkvl_pkg::REPORT_W{1'b0}}, vlen_next};

    assign res_valid        = byte_en && last_byte;
    assign res.found        = found_next;
    assign res.value_offset = found_next ? start_ext[jkvl_pkg::REPORT_W-1:0] : '0;
    assign res.value_length = found_next ? len_ext[jkvl_pkg::REPORT_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            pos_reg    <= '0;
            depth_reg  <= '0;
            quote_reg  <= 1'b0;
            kidx_reg   <= '0;
            vstart_reg <= '0;
            vend_reg   <= '0;
        end else if (byte_en) begin
            if (last_byte) begin
                // Document done: start fresh for the next one
                phase_reg  <= PH_START;
                pos_reg    <= '0;
                depth_reg  <= '0;
                quote_reg  <= 1'b0;
                kidx_reg   <= '0;
                vstart_reg <= '0;
                vend_reg   <= '0;
            end else begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_inc;
                depth_reg  <= depth_next;
                quote_reg  <= quote_next;
                kidx_reg   <= kidx_next;
                vstart_reg <= vstart_next;
                vend_reg   <= vend_next;
            end
        end
    end

    a_nested_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NESTED) |-> (depth_reg != '0))
        else $error("nested phase with zero brace depth");

    a_depth_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg != PH_NESTED) && (phase_reg != PH_VALUE)) |-> (depth_reg == '0))
        else $error("brace depth left over outside nested or value phase");

    a_quote_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg != PH_NESTED) && (phase_reg != PH_VALUE)) |-> !quote_reg)
        else $error("quote open outside nested or value phase");

    a_kidx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME) |-> (kidx_reg <= eff_len))
        else $error("key match index past key length");

    a_doc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_en && last_byte) |=> ((phase_reg == PH_START) && (pos_reg == '0)))
        else $error("document state not cleared after last byte");

endmodule

`default_nettype wire

[rtl/core/json_key_value_locator.sv]
`default_nettype none

// JSON key/value locator.
// Documents stream in on the s_ channel one byte per item; s_last_byte marks
// the final byte. The block looks for the configured key among the quoted
// names of the top-level object (ASCII case folded) and, on the last byte,
// delivers one item on the m_ channel: found flag, byte offset of the value
// and trimmed value length (both zero when not found).
// The key is set through the write port (cfg_wr_en, cfg_index, cfg_wdata):
// index 0 key length, 1 key bytes 0..7, 2 key bytes 8..15. Write it only
// between documents.
// Throughput: one byte per cycle while s_ready is high; the scan state
// updates in the cycle the byte is taken. The result of the last byte is
// registered into the output register, or parks in the skid entry if held.
// Stall: a result register plus a one-entry skid register hold results
// while m_ready is low; bytes keep flowing until the skid entry fills, then
// s_ready drops until the receiver takes an item.
// Reset (aresetn, synchronous, active low) empties both result registers,
// clears the scan state and sets the key length to one, key bytes to zero.
module json_key_value_locator #(
    parameter int MAX_KEY_BYTES = jkvl_pkg::MAX_KEY_BYTES_DEF,
    parameter int OFFSET_BITS   = jkvl_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [jkvl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jkvl_pkg::KEY_WORD_W-1:0]     cfg_wdata,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [jkvl_pkg::BYTE_W-1:0]         s_doc_byte,
    input  wire logic                                s_last_byte,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_found,
    output logic [jkvl_pkg::REPORT_W-1:0]            m_value_offset,
    output logic [jkvl_pkg::REPORT_W-1:0]            m_value_length
);

    // Key registers
    logic [jkvl_pkg::KEY_LEN_W-1:0]   key_len_reg;
    logic [jkvl_pkg::KEY_WORD_W-1:0]  key_low_reg;
    logic [jkvl_pkg::KEY_WORD_W-1:0]  key_high_reg;

    // Result register and skid entry
    logic                             out_valid_reg;
    jkvl_pkg::result_t                out_reg;
    logic                             skid_valid_reg;
    jkvl_pkg::result_t                skid_reg;

    logic                             byte_en;
    logic                             res_valid;
    jkvl_pkg::result_t                res;
    logic                             pop;

    // Take a byte whenever the skid entry is free
    assign s_ready = !skid_valid_reg;
    assign byte_en = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg  <= jkvl_pkg::KEY_LEN_W'(1);
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                jkvl_pkg::CFG_KEY_LENGTH: key_len_reg  <= cfg_wdata[jkvl_pkg::KEY_LEN_W-1:0];
                jkvl_pkg::CFG_KEY_LOW:    key_low_reg  <= cfg_wdata;
                jkvl_pkg::CFG_KEY_HIGH:   key_high_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    jkvl_scan #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key_length (key_len_reg),
        .key_bytes  ({key_high_reg, key_low_reg}),
        .byte_en    (byte_en),
        .doc_byte   (s_doc_byte),
        .last_byte  (s_last_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result buffering: the skid entry drains into the output register first;
    // a new result goes straight out when the output register frees up,
    // otherwise it parks in the skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || pop) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_found        = out_reg.found;
    assign m_value_offset = out_reg.value_offset;
    assign m_value_length = out_reg.value_length;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while output register is empty");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> out_valid_reg)
        else $error("result produced but output register empty next cycle");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("stalled result not parked in skid entry");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> (skid_valid_reg && out_valid_reg))
        else $error("buffered item lost while receiver stalls");

endmodule

`default_nettype wire
